### rtl/rtdc_pkg.sv
// ----------------------------------------------------------------------------
// rtdc_pkg
// Types and constants for the relay threshold duty controller.
// ----------------------------------------------------------------------------
package rtdc_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int MS_BITS        = 26;
    localparam int MS_PER_SEC     = 1000;
    localparam int NOW_BITS       = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULE_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_MODE       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SWITCH_DIRECTION = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_USE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TEMP_THRESHOLD   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HUM_THRESHOLD    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ON_SECONDS   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REST_SECONDS     = 3'd7;

    localparam logic [1:0] DRIVE_AUTO = 2'd0;
    localparam logic [1:0] DRIVE_ON   = 2'd1;
    localparam logic [1:0] DRIVE_OFF  = 2'd2;

    localparam logic signed [11:0] TEMP_THRESHOLD_RESET = 12'sd250;
    localparam logic [9:0]         HUM_THRESHOLD_RESET  = 10'd500;

    typedef struct packed {
        logic [NOW_BITS-1:0] now_ms;
        logic signed [11:0]  temperature;
        logic [9:0]          humidity;
    } t_in_req;

    typedef struct packed {
        logic relay_on;
        logic resting;
    } t_out_req;

endpackage

### rtl/relay_threshold_duty_controller.sv
// ----------------------------------------------------------------------------
// relay_threshold_duty_controller
// On/off thermostat and humidistat with a maximum on-time and a forced rest.
//
//   channel  direction  handshake               payload
//   in       request    i_in_valid / o_in_stall  i_in  (t_in_req)
//   out      result     o_out_valid / i_out_stall o_out (t_out_req)
//   cfg      write      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle while the result is not stalled; a taken request
// passes through the input register, then the result register.
// Each pass is one subtract-and-compare per timer against millisecond limits
// that are scaled when the seconds registers are written.
// Reset is synchronous and active low; it clears valid bits and state.
// A stalled result holds the result register; the input register keeps
// taking requests until it too is full.
// ----------------------------------------------------------------------------
module relay_threshold_duty_controller
    import rtdc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_req                   i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_req                  o_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int NOW_USE = (TIME_BITS < NOW_BITS) ? TIME_BITS : NOW_BITS;
    localparam int CMP_BITS = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;

    logic                 r_module_enable;
    logic [1:0]           r_drive_mode;
    logic                 r_switch_direction;
    logic [1:0]           r_threshold_use;
    logic signed [11:0]   r_temp_threshold;
    logic [9:0]           r_hum_threshold;
    logic [MS_BITS-1:0]   r_max_on_ms;
    logic [MS_BITS-1:0]   r_rest_ms;

    logic                 r_relay_state;
    logic                 r_rest_flag;
    logic [TIME_BITS-1:0] r_work_start;
    logic [TIME_BITS-1:0] r_rest_start;

    logic                 r_in_valid;
    t_in_req              r_in;
    logic                 r_out_valid;
    t_out_req             r_out;

    logic                 n_relay_state;
    logic                 n_rest_flag;
    logic [TIME_BITS-1:0] n_work_start;
    logic [TIME_BITS-1:0] n_rest_start;

    logic                 out_load_ok;
    logic                 fire;
    logic                 in_take;
    logic                 cfg_we;
    logic [MS_BITS-1:0]   cfg_ms;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] work_elapsed;
    logic [TIME_BITS-1:0] rest_elapsed;
    logic                 work_over;
    logic                 rest_done;
    logic                 temp_demand;
    logic                 hum_demand;
    logic                 demand;
    logic                 run_check;

    // Configuration
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_ms      = MS_BITS'(i_cfg_data) * MS_BITS'(MS_PER_SEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_enable    <= 1'b1;
            r_drive_mode       <= DRIVE_AUTO;
            r_switch_direction <= 1'b0;
            r_threshold_use    <= 2'd0;
            r_temp_threshold   <= TEMP_THRESHOLD_RESET;
            r_hum_threshold    <= HUM_THRESHOLD_RESET;
            r_max_on_ms        <= '0;
            r_rest_ms          <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODULE_ENABLE:    r_module_enable    <= i_cfg_data[0];
                CFG_DRIVE_MODE:       r_drive_mode       <= i_cfg_data[1:0];
                CFG_SWITCH_DIRECTION: r_switch_direction <= i_cfg_data[0];
                CFG_THRESHOLD_USE:    r_threshold_use    <= i_cfg_data[1:0];
                CFG_TEMP_THRESHOLD:   r_temp_threshold   <= i_cfg_data[11:0];
                CFG_HUM_THRESHOLD:    r_hum_threshold    <= i_cfg_data[9:0];
                CFG_MAX_ON_SECONDS:   r_max_on_ms        <= cfg_ms;
                CFG_REST_SECONDS:     r_rest_ms          <= cfg_ms;
                default: ;
            endcase
        end
    end

    // Handshake
    assign out_load_ok = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_load_ok;
    assign o_in_stall  = r_in_valid && !out_load_ok;
    assign in_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    // Control pass
    assign now_t        = TIME_BITS'(r_in.now_ms[NOW_USE-1:0]);
    assign work_elapsed = now_t - r_work_start;
    assign rest_elapsed = now_t - r_rest_start;
    assign work_over    = CMP_BITS'(work_elapsed) > CMP_BITS'(r_max_on_ms);
    assign rest_done    = CMP_BITS'(rest_elapsed) > CMP_BITS'(r_rest_ms);

    assign temp_demand = r_threshold_use[0] && (r_switch_direction ?
                         (r_in.temperature > r_temp_threshold) :
                         (r_in.temperature < r_temp_threshold));
    assign hum_demand  = r_threshold_use[1] && (r_switch_direction ?
                         (r_in.humidity > r_hum_threshold) :
                         (r_in.humidity < r_hum_threshold));
    assign demand      = temp_demand || hum_demand;

    always_comb begin
        n_relay_state = r_relay_state;
        n_rest_flag   = r_rest_flag;
        n_work_start  = r_work_start;
        n_rest_start  = r_rest_start;
        run_check     = 1'b0;
        if (!r_module_enable) begin
            n_relay_state = 1'b0;
        end else begin
            unique case (r_drive_mode)
                DRIVE_ON:  n_relay_state = 1'b1;
                DRIVE_OFF: n_relay_state = 1'b0;
                DRIVE_AUTO: begin
                    if (r_rest_flag) begin
                        if (rest_done) begin
                            n_rest_flag = 1'b0;
                            run_check   = 1'b1;
                        end
                    end else if (r_relay_state && (r_max_on_ms != '0) && work_over) begin
                        n_rest_flag   = 1'b1;
                        n_rest_start  = now_t;
                        n_relay_state = 1'b0;
                    end else begin
                        run_check = 1'b1;
                    end
                    if (run_check) begin
                        if (demand) begin
                            if (!r_relay_state) begin
                                n_work_start = now_t;
                            end
                            n_relay_state = 1'b1;
                        end else begin
                            n_relay_state = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_state <= 1'b0;
            r_rest_flag   <= 1'b0;
            r_work_start  <= '0;
            r_rest_start  <= '0;
        end else if (fire) begin
            r_relay_state <= n_relay_state;
            r_rest_flag   <= n_rest_flag;
            r_work_start  <= n_work_start;
            r_rest_start  <= n_rest_start;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.relay_on <= n_relay_state;
            r_out.resting  <= n_rest_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_disable_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_module_enable) |=> !r_relay_state)
        else $error("relay not off after pass with module disabled");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out.relay_on == r_relay_state) && (r_out.resting == r_rest_flag))
        else $error("result register differs from controller state");

    a_rest_only_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rest_flag) |-> ($past(r_drive_mode) == DRIVE_AUTO) && $past(r_module_enable))
        else $error("rest started outside automatic mode");

    a_rest_relay_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rest_flag) |-> !r_relay_state)
        else $error("relay on at start of rest");

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for relay_threshold_duty_controller. Control passes go
// in on the request channel; a behavioral mirror of the relay, rest flag and
// timers predicts every result request, which is checked field by field.
// Directed passes cover forced modes, compare edges and the on-time limit
// with rest; random phases then reshuffle the registers between bursts.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtdc_pkg::*;

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         IDLE_PCT        = 7;
    localparam int         PHASES          = 35;
    localparam int         ITEMS_PER_PHASE = 40;
    localparam int         QUIET_FIRST     = 12;
    localparam int         QUIET_LAST      = 17;
    localparam logic [1:0] DRIVE_UNUSED    = 2'd3;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_req                   i_in        = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_req                  o_out;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    // register mirror
    logic               ctl_enable   = 1'b1;
    logic [1:0]         ctl_mode     = DRIVE_AUTO;
    logic               ctl_dir      = 1'b0;
    logic [1:0]         ctl_use      = 2'd0;
    logic signed [11:0] ctl_temp_thr = TEMP_THRESHOLD_RESET;
    logic [9:0]         ctl_hum_thr  = HUM_THRESHOLD_RESET;
    logic [15:0]        ctl_max_on   = 16'd0;
    logic [15:0]        ctl_rest     = 16'd0;

    // controller state mirror
    logic        relay_st      = 1'b0;
    logic        rest_st       = 1'b0;
    logic [31:0] work_start_ms = 32'd0;
    logic [31:0] rest_start_ms = 32'd0;

    t_out_req    pending_relay_q[$];
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          quiet       = 1'b0;
    bit          want_on     = 1'b0;
    logic [31:0] now_ms      = 32'd0;

    relay_threshold_duty_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial forever #5 i_clk = ~i_clk;

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic bit elapsed_over(input logic [31:0] now, input logic [31:0] start,
                                        input logic [15:0] secs);
        logic [31:0] span;
        span = now - start;
        return span > 32'(secs) * 32'(MS_PER_SEC);
    endfunction

    function automatic bit reading_demand(input logic signed [11:0] temp,
                                          input logic [9:0] hum);
        bit hit;
        hit = 1'b0;
        if (ctl_use[0] && (ctl_dir ? (temp > ctl_temp_thr) : (temp < ctl_temp_thr)))
            hit = 1'b1;
        if (ctl_use[1] && (ctl_dir ? (hum > ctl_hum_thr) : (hum < ctl_hum_thr)))
            hit = 1'b1;
        return hit;
    endfunction

    function automatic t_out_req predict_relay(input t_in_req req);
        t_out_req res;
        bit       check;
        check = 1'b0;
        if (!ctl_enable) begin
            relay_st = 1'b0;
        end else if (ctl_mode == DRIVE_ON) begin
            relay_st = 1'b1;
        end else if (ctl_mode == DRIVE_OFF) begin
            relay_st = 1'b0;
        end else if (ctl_mode == DRIVE_AUTO) begin
            check = 1'b1;
            if (rest_st) begin
                if (elapsed_over(req.now_ms, rest_start_ms, ctl_rest))
                    rest_st = 1'b0;
                else
                    check = 1'b0;
            end else if (relay_st && ctl_max_on != 16'd0 &&
                         elapsed_over(req.now_ms, work_start_ms, ctl_max_on)) begin
                rest_st       = 1'b1;
                rest_start_ms = req.now_ms;
                relay_st      = 1'b0;
                check         = 1'b0;
            end
        end
        if (check) begin
            if (reading_demand(req.temperature, req.humidity)) begin
                if (!relay_st) begin
                    work_start_ms = req.now_ms;
                    relay_st      = 1'b1;
                end
            end else begin
                relay_st = 1'b0;
            end
        end
        res.relay_on = relay_st;
        res.resting  = rest_st;
        return res;
    endfunction

    function automatic void apply_cfg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_MODULE_ENABLE:    ctl_enable   = data[0];
            CFG_DRIVE_MODE:       ctl_mode     = data[1:0];
            CFG_SWITCH_DIRECTION: ctl_dir      = data[0];
            CFG_THRESHOLD_USE:    ctl_use      = data[1:0];
            CFG_TEMP_THRESHOLD:   ctl_temp_thr = data[11:0];
            CFG_HUM_THRESHOLD:    ctl_hum_thr  = data[9:0];
            CFG_MAX_ON_SECONDS:   ctl_max_on   = data;
            CFG_REST_SECONDS:     ctl_rest     = data;
            default: ;
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_relay_q.size() != 0);
    endtask

    task automatic send_request(input logic [31:0] now, input logic [11:0] temp,
                                input logic [9:0] hum);
        t_in_req req;
        req.now_ms      = now;
        req.temperature = temp;
        req.humidity    = hum;
        if (!quiet && chance(IDLE_PCT)) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_relay_q.push_back(predict_relay(req));
    endtask

    task automatic test_power_on_defaults;
        send_request(32'h0000_0000, 12'h800, 10'd0);
        send_request(32'hFFFF_FFFF, 12'h7FF, 10'h3FF);
    endtask

    task automatic test_forced_modes;
        wait_idle();
        cfg_write(CFG_DRIVE_MODE, 16'(DRIVE_ON));
        send_request(32'd100, 12'd0, 10'd0);
        wait_idle();
        cfg_write(CFG_DRIVE_MODE, 16'(DRIVE_UNUSED));
        send_request(32'd200, 12'd0, 10'd0);
        wait_idle();
        cfg_write(CFG_DRIVE_MODE, 16'(DRIVE_OFF));
        send_request(32'd300, 12'd0, 10'd0);
        wait_idle();
        cfg_write(CFG_DRIVE_MODE, 16'(DRIVE_ON));
        cfg_write(CFG_MODULE_ENABLE, 16'd0);
        send_request(32'd400, 12'd0, 10'd0);
        wait_idle();
        cfg_write(CFG_MODULE_ENABLE, 16'd1);
        cfg_write(CFG_DRIVE_MODE, 16'(DRIVE_AUTO));
    endtask

    task automatic test_threshold_edges;
        wait_idle();
        cfg_write(CFG_THRESHOLD_USE, 16'd1);
        cfg_write(CFG_SWITCH_DIRECTION, 16'd0);
        send_request(32'd1000, 12'd249, 10'd0);
        send_request(32'd1100, 12'd250, 10'd0);
        wait_idle();
        cfg_write(CFG_SWITCH_DIRECTION, 16'd1);
        send_request(32'd1200, 12'd251, 10'd0);
        send_request(32'd1300, 12'd250, 10'd0);
        wait_idle();
        cfg_write(CFG_THRESHOLD_USE, 16'd2);
        send_request(32'd1400, 12'd0, 10'd501);
        send_request(32'd1500, 12'd0, 10'd500);
        wait_idle();
        cfg_write(CFG_THRESHOLD_USE, 16'd3);
        cfg_write(CFG_SWITCH_DIRECTION, 16'd0);
        send_request(32'd1600, 12'd249, 10'd500);
        send_request(32'd1700, 12'd250, 10'd499);
        wait_idle();
        cfg_write(CFG_TEMP_THRESHOLD, 16'hF800);
        cfg_write(CFG_HUM_THRESHOLD, 16'd0);
        send_request(32'd1800, 12'h800, 10'd0);
        wait_idle();
        cfg_write(CFG_SWITCH_DIRECTION, 16'd1);
        cfg_write(CFG_TEMP_THRESHOLD, 16'h07FF);
        cfg_write(CFG_HUM_THRESHOLD, 16'h03FF);
        send_request(32'd1900, 12'h7FF, 10'h3FF);
    endtask

    task automatic test_on_time_limit;
        logic [31:0] base;
        base = 32'hFFFF_FC00;
        wait_idle();
        cfg_write(CFG_THRESHOLD_USE, 16'd1);
        cfg_write(CFG_SWITCH_DIRECTION, 16'd1);
        cfg_write(CFG_TEMP_THRESHOLD, 16'd0);
        cfg_write(CFG_MAX_ON_SECONDS, 16'd2);
        cfg_write(CFG_REST_SECONDS, 16'd1);
        send_request(base, -12'sd100, 10'd0);
        send_request(base, 12'd100, 10'd0);
        send_request(base + 32'd2000, 12'd100, 10'd0);
        send_request(base + 32'd2001, 12'd100, 10'd0);
        send_request(base + 32'd3001, 12'd100, 10'd0);
        send_request(base + 32'd3002, 12'd100, 10'd0);
        wait_idle();
        cfg_write(CFG_MAX_ON_SECONDS, 16'd0);
        send_request(base + 32'd200000, 12'd100, 10'd0);
        wait_idle();
        cfg_write(CFG_MAX_ON_SECONDS, 16'hFFFF);
        cfg_write(CFG_REST_SECONDS, 16'hFFFF);
        send_request(base + 32'd300000, 12'd100, 10'd0);
    endtask

    task automatic test_random_passes;
        int r;
        int mag;
        int tv;
        int hv;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            quiet = (ph >= QUIET_FIRST && ph <= QUIET_LAST);
            if (chance(25))
                cfg_write(CFG_MODULE_ENABLE, chance(85) ? 16'd1 : 16'd0);
            if (chance(35))
                cfg_write(CFG_DRIVE_MODE,
                          chance(70) ? 16'(DRIVE_AUTO) : 16'($urandom_range(3, 1)));
            if (chance(30))
                cfg_write(CFG_SWITCH_DIRECTION, 16'($urandom_range(1, 0)));
            if (chance(30))
                cfg_write(CFG_THRESHOLD_USE, chance(10) ? 16'd0 : 16'($urandom_range(3, 1)));
            if (chance(30))
                cfg_write(CFG_TEMP_THRESHOLD,
                          chance(20) ? 16'($urandom) : 16'($urandom_range(1650, 0) - 400));
            if (chance(30))
                cfg_write(CFG_HUM_THRESHOLD,
                          chance(20) ? 16'($urandom) : 16'($urandom_range(1000, 0)));
            if (chance(40)) begin
                r = $urandom_range(99, 0);
                cfg_write(CFG_MAX_ON_SECONDS,
                          (r < 30) ? 16'd0 :
                          (r < 80) ? 16'($urandom_range(3, 1)) :
                          (r < 90) ? 16'hFFFF : 16'($urandom));
            end
            if (chance(40)) begin
                r = $urandom_range(99, 0);
                cfg_write(CFG_REST_SECONDS,
                          (r < 70) ? 16'($urandom_range(3, 0)) :
                          (r < 85) ? 16'hFFFF : 16'($urandom));
            end
            if (ph == 0 || chance(20))
                now_ms = $urandom;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(99, 0);
                if (r < 78) begin
                    now_ms = now_ms + $urandom_range(900, 50);
                end else if (r >= 86 && r < 93) begin
                    now_ms = $urandom;
                end else if (r >= 93) begin
                    // land on or just past the active timer limit
                    now_ms = (rest_st ? rest_start_ms + 32'(ctl_rest) * 32'(MS_PER_SEC)
                                      : work_start_ms + 32'(ctl_max_on) * 32'(MS_PER_SEC))
                             + $urandom_range(1, 0);
                end
                if (chance(8))
                    want_on = !want_on;
                mag = want_on ? int'($urandom_range(60, 1)) : int'($urandom_range(59, 0));
                tv  = int'(ctl_temp_thr) + ((want_on == ctl_dir) ? mag : -mag);
                if (chance(10))
                    tv = $urandom;
                mag = want_on ? int'($urandom_range(60, 1)) : int'($urandom_range(59, 0));
                hv  = int'(ctl_hum_thr) + ((want_on == ctl_dir) ? mag : -mag);
                if (chance(10))
                    hv = $urandom;
                send_request(now_ms, tv[11:0], hv[9:0]);
            end
        end
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !quiet && chance(IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_relay_q.size() == 0) begin
                $display("%0t: result request with none pending, relay_on=%0b resting=%0b",
                         $time, o_out.relay_on, o_out.resting);
                err_count++;
            end else begin
                want = pending_relay_q.pop_front();
                if (o_out.relay_on !== want.relay_on) begin
                    $display("%0t: relay_on mismatch, expected %0b, actual %0b",
                             $time, want.relay_on, o_out.relay_on);
                    err_count++;
                end
                if (o_out.resting !== want.resting) begin
                    $display("%0t: resting mismatch, expected %0b, actual %0b",
                             $time, want.resting, o_out.resting);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_relay_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_power_on_defaults();
        test_forced_modes();
        test_threshold_edges();
        test_on_time_limit();
        test_random_passes();
        wait_idle();
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
